>>> sv/u8v_pkg.sv
// Package for the UTF-8 validator: item structs, string state, status codes and
// the byte constants used by the lead and continuation checks. No dependencies.
`default_nettype none

package u8v_pkg;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_INVALID = 2'd1,
    ERR_FULL    = 2'd2
  } err_t;

  localparam logic [7:0] BYTE_ASCII_TOP = 8'h80;
  localparam logic [7:0] MASK_CONT      = 8'hC0;
  localparam logic [7:0] MASK_3BIT      = 8'hE0;
  localparam logic [7:0] MASK_4BIT      = 8'hF0;
  localparam logic [7:0] MASK_LOW1      = 8'hFE;
  localparam logic [7:0] LEAD_2_MIN     = 8'hC2;
  localparam logic [7:0] LEAD_2_MAX     = 8'hDF;
  localparam logic [7:0] LEAD_3_BASE    = 8'hE0;
  localparam logic [7:0] LEAD_4_MIN     = 8'hF0;
  localparam logic [7:0] LEAD_4_MAX     = 8'hF4;
  localparam logic [7:0] LEAD_SURR      = 8'hED;
  localparam logic [7:0] LEAD_EF        = 8'hEF;
  localparam logic [7:0] CONT_BASE      = 8'h80;
  localparam logic [7:0] CONT_SURR      = 8'hA0;
  localparam logic [7:0] CONT_BF        = 8'hBF;
  localparam logic [7:0] CONT_BE        = 8'hBE;
  localparam logic [7:0] CONT_F4_MAX    = 8'h8F;
  localparam logic [6:0] CHAR_SUBST     = 7'h3F;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        char_valid;
    logic [6:0]  out_char;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] char_count;
    logic        saw_multibyte;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  cont_left;
    logic [7:0]  lead;
    logic [7:0]  second;
    logic [15:0] count;
    logic        multibyte;
    err_t        err;
  } str_state_t;

endpackage

`default_nettype wire

>>> sv/u8v_stream_if.sv
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on nothing; payload fields carry the item fields by name.
`default_nettype none

interface u8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
  modport mon    (input valid, input in_byte, input last_byte, input ready);
endinterface

interface u8v_out_if;
  logic        valid;
  logic        ready;
  logic        char_valid;
  logic [6:0]  out_char;
  logic        done_res;
  logic [1:0]  status;
  logic [15:0] char_count;
  logic        saw_multibyte;

  modport source (output valid, output char_valid, output out_char, output done_res,
                  output status, output char_count, output saw_multibyte, input ready);
  modport sink   (input valid, input char_valid, input out_char, input done_res,
                  input status, input char_count, input saw_multibyte, output ready);
  modport mon    (input valid, input char_valid, input out_char, input done_res,
                  input status, input char_count, input saw_multibyte, input ready);
endinterface

`default_nettype wire

>>> sv/u8v_step.sv
// Combinational per-byte step: decodes one byte against the string state and
// produces the next state and the result item. Uses u8v_pkg.
`default_nettype none

module u8v_step (
  input  u8v_pkg::str_state_t st_i,
  input  u8v_pkg::in_item_t   item_i,
  input  logic [15:0]         max_chars_i,
  output u8v_pkg::str_state_t st_o,
  output u8v_pkg::out_item_t  res_o
);

  always_comb begin
    u8v_pkg::str_state_t nx;
    logic [7:0] b;
    logic [1:0] total;
    logic [1:0] pos;
    logic       cont_ok;
    logic       can_emit;
    logic       emit;
    logic [6:0] ch;

    nx       = st_i;
    b        = item_i.in_byte;
    emit     = 1'b0;
    ch       = '0;
    can_emit = (st_i.count < max_chars_i);

    if (st_i.lead >= u8v_pkg::LEAD_4_MIN) begin
      total = 2'd3;
    end else if (st_i.lead >= u8v_pkg::LEAD_3_BASE) begin
      total = 2'd2;
    end else begin
      total = 2'd1;
    end
    pos = total - st_i.cont_left + 2'd1;

    cont_ok = ((b & u8v_pkg::MASK_CONT) == u8v_pkg::CONT_BASE);
    if (pos == 2'd1) begin
      if (st_i.lead == u8v_pkg::LEAD_3_BASE && (b & u8v_pkg::MASK_3BIT) == u8v_pkg::CONT_BASE)
        cont_ok = 1'b0;
      if (st_i.lead == u8v_pkg::LEAD_SURR && (b & u8v_pkg::MASK_3BIT) == u8v_pkg::CONT_SURR)
        cont_ok = 1'b0;
      if (st_i.lead == u8v_pkg::LEAD_4_MIN && (b & u8v_pkg::MASK_4BIT) == u8v_pkg::CONT_BASE)
        cont_ok = 1'b0;
      if (st_i.lead == u8v_pkg::LEAD_4_MAX && b > u8v_pkg::CONT_F4_MAX)
        cont_ok = 1'b0;
    end else if (pos == 2'd2) begin
      // U+FFFE and U+FFFF are rejected on their third byte.
      if (st_i.lead == u8v_pkg::LEAD_EF && st_i.second == u8v_pkg::CONT_BF &&
          (b & u8v_pkg::MASK_LOW1) == u8v_pkg::CONT_BE)
        cont_ok = 1'b0;
    end

    if (st_i.err == u8v_pkg::ERR_NONE) begin
      if (st_i.cont_left == 2'd0) begin
        nx.lead   = '0;
        nx.second = '0;
        if (b < u8v_pkg::BYTE_ASCII_TOP) begin
          emit = 1'b1;
          ch   = b[6:0];
        end else if (b >= u8v_pkg::LEAD_2_MIN && b <= u8v_pkg::LEAD_2_MAX) begin
          nx.lead      = b;
          nx.cont_left = 2'd1;
        end else if ((b & u8v_pkg::MASK_4BIT) == u8v_pkg::LEAD_3_BASE) begin
          nx.lead      = b;
          nx.cont_left = 2'd2;
        end else if (b >= u8v_pkg::LEAD_4_MIN && b <= u8v_pkg::LEAD_4_MAX) begin
          nx.lead      = b;
          nx.cont_left = 2'd3;
        end else begin
          nx.err = u8v_pkg::ERR_INVALID;
        end
      end else if (!cont_ok) begin
        nx.err       = u8v_pkg::ERR_INVALID;
        nx.cont_left = 2'd0;
      end else begin
        if (pos == 2'd1)
          nx.second = b;
        nx.cont_left = st_i.cont_left - 2'd1;
        if (st_i.cont_left == 2'd1) begin
          emit = 1'b1;
          ch   = u8v_pkg::CHAR_SUBST;
        end
      end
    end

    res_o.char_valid = 1'b0;
    res_o.out_char   = '0;
    if (emit) begin
      if (can_emit) begin
        nx.count         = st_i.count + 16'd1;
        res_o.char_valid = 1'b1;
        res_o.out_char   = ch;
        if (ch == u8v_pkg::CHAR_SUBST && st_i.cont_left != 2'd0)
          nx.multibyte = 1'b1;
      end else begin
        nx.err = u8v_pkg::ERR_FULL;
      end
    end

    // A sequence still open at the end of the string is cut short.
    if (item_i.last_byte && nx.err == u8v_pkg::ERR_NONE && nx.cont_left != 2'd0)
      nx.err = u8v_pkg::ERR_INVALID;

    res_o.done_res      = item_i.last_byte;
    res_o.status        = nx.err;
    res_o.char_count    = nx.count;
    res_o.saw_multibyte = nx.multibyte;

    if (item_i.last_byte)
      nx = '0;

    st_o = nx;
  end

endmodule

`default_nettype wire

>>> sv/utf8_validate_to_ascii.sv
// Top level of the streaming strict UTF-8 checker: input register, step logic,
// result register and the capacity register. Uses u8v_pkg, u8v_stream_if, u8v_step.
//
//   channel   direction  handshake     payload
//   in_chan   in         valid/ready   in_byte[7:0], last_byte
//   out_chan  out        valid/ready   char_valid, out_char[6:0], done_res,
//                                      status[1:0], char_count[15:0], saw_multibyte
//   cfg_*     in         write enable  cfg_wr_data[15:0] = max_output_chars
//
// One byte per cycle sustained while out_chan is ready; each request passes through the
// input register, then the result register, before it is offered on out_chan.
// The string state is updated as a byte moves from the input to the result register.
// When out_chan stalls, the result register holds, and in_chan.ready drops as soon
// as the input register holds a byte.
// Reset (rst_n low, synchronous) empties both registers, clears the string state
// and sets the capacity to 65535.
`default_nettype none

module utf8_validate_to_ascii (
  input  logic        clk,
  input  logic        rst_n,
  u8v_in_if.sink      in_chan,
  u8v_out_if.source   out_chan,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic                in_v_r;
  u8v_pkg::in_item_t   in_data_r;
  logic                out_v_r;
  u8v_pkg::out_item_t  out_data_r;
  u8v_pkg::str_state_t st_r;
  u8v_pkg::str_state_t st_nxt;
  u8v_pkg::out_item_t  res_nxt;
  logic [15:0]         max_r;
  logic                adv;
  logic                in_take;

  assign adv     = in_v_r && (!out_v_r || out_chan.ready);
  assign in_take = in_chan.valid && in_chan.ready;
  assign in_chan.ready = !in_v_r || adv;

  u8v_step u_step (
    .st_i        (st_r),
    .item_i      (in_data_r),
    .max_chars_i (max_r),
    .st_o        (st_nxt),
    .res_o       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= '0;
      max_r   <= 16'hFFFF;
    end else begin
      if (cfg_wr_en)
        max_r <= cfg_wr_data;
      if (in_take)
        in_v_r <= 1'b1;
      else if (adv)
        in_v_r <= 1'b0;
      if (adv) begin
        out_v_r <= 1'b1;
        st_r    <= st_nxt;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take)
      in_data_r <= '{in_byte: in_chan.in_byte, last_byte: in_chan.last_byte};
    if (adv)
      out_data_r <= res_nxt;
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.char_valid    = out_data_r.char_valid;
  assign out_chan.out_char      = out_data_r.out_char;
  assign out_chan.done_res      = out_data_r.done_res;
  assign out_chan.status        = out_data_r.status;
  assign out_chan.char_count    = out_data_r.char_count;
  assign out_chan.saw_multibyte = out_data_r.saw_multibyte;

endmodule

`default_nettype wire

>>> sv/u8v_checker.sv
// Port-level checker for utf8_validate_to_ascii, attached by the bind below.
// Depends on u8v_pkg and the top level's result channel signals.
`default_nettype none

module u8v_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_char_valid,
  input logic [6:0]  out_char,
  input logic [1:0]  out_status,
  input logic [15:0] out_char_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_char_count) &&
    $stable(out_status) && $stable(out_char))
    else $error("stalled result changed");

  a_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_valid |-> out_status == u8v_pkg::ERR_NONE)
    else $error("character emitted with an error status");

  a_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_char_valid |-> out_char == 7'd0)
    else $error("character field set without an emitted character");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == u8v_pkg::ERR_NONE || out_status == u8v_pkg::ERR_INVALID ||
                   out_status == u8v_pkg::ERR_FULL))
    else $error("undefined status code");

endmodule

bind utf8_validate_to_ascii u8v_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_char_valid (out_chan.char_valid),
  .out_char       (out_chan.out_char),
  .out_status     (out_chan.status),
  .out_char_count (out_chan.char_count)
);

`default_nettype wire
